// ----- hdl/smm_pkg.sv -----
// shared constants, types and helpers of the strassen matrix multiplier
package smm_pkg;

   localparam int WORD_BITS = 32;
   localparam int DIM_MAX   = 8;
   localparam int IDX_BITS  = 3;
   localparam int ADDR_BITS = 2 * IDX_BITS;
   localparam int DEPTH     = DIM_MAX * DIM_MAX;
   localparam int CALL_BITS = 10;
   localparam int CFG_BITS  = 4;

   localparam logic [1:0] FUNC_LOAD_A   = 2'd0;
   localparam logic [1:0] FUNC_LOAD_B   = 2'd1;
   localparam logic [1:0] FUNC_MULTIPLY = 2'd2;

   localparam logic CFG_MATRIX_SIZE      = 1'b0;
   localparam logic CFG_DIRECT_THRESHOLD = 1'b1;

   localparam logic [CFG_BITS-1:0] SIZE_RESET = 4'd8;
   localparam logic [CFG_BITS-1:0] THR_RESET  = 4'd1;

   typedef struct packed {
      logic                 issue;
      logic                 first;
      logic                 last_z;
      logic                 last_elem;
      logic [IDX_BITS-1:0]  row;
      logic [IDX_BITS-1:0]  col;
      logic [IDX_BITS-1:0]  inner;
      logic [CALL_BITS-1:0] calls;
   } cmd_type;

   // recursion count of the seven-product scheme for side n_eff padded to a power of two
   function automatic logic [CALL_BITS-1:0] calc_calls(input logic [CFG_BITS-1:0] n_eff,
                                                       input logic [CFG_BITS-1:0] thr_eff);
      logic [CALL_BITS-1:0] c2;
      logic [CALL_BITS-1:0] c4;
      logic [CALL_BITS-1:0] c8;
      logic [CALL_BITS-1:0] res;
      c2 = (thr_eff >= 4'd2) ? 10'd1 : 10'd8;
      c4 = (thr_eff >= 4'd4) ? 10'd1 : 10'(10'd1 + 10'd7 * c2);
      c8 = (thr_eff >= 4'd8) ? 10'd1 : 10'(10'd1 + 10'd7 * c4);
      if (n_eff <= 4'd1) res = 10'd1;
      else if (n_eff == 4'd2) res = c2;
      else if (n_eff <= 4'd4) res = c4;
      else res = c8;
      return res;
   endfunction

endpackage

// ----- hdl/smm_ram.sv -----
// generic single-write, single-read ram with registered read data
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/smm_ctrl.sv -----
// sequencer walking row, column and inner index of the product
module smm_ctrl import smm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [CFG_BITS-1:0] cfg_size,
   input  logic [CFG_BITS-1:0] cfg_thr,
   output logic                busy,
   output cmd_type             cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_type;

   state_type            state_ff;
   logic [IDX_BITS-1:0]  row_ff;
   logic [IDX_BITS-1:0]  col_ff;
   logic [IDX_BITS-1:0]  inner_ff;
   logic [IDX_BITS-1:0]  nm1_ff;
   logic [CALL_BITS-1:0] calls_ff;
   logic [1:0]           drain_ff;

   logic [CFG_BITS-1:0]  n_in;
   logic [CFG_BITS-1:0]  thr_in;

   always_comb begin
      n_in = cfg_size;
      if (cfg_size == 4'd0) n_in = 4'd1;
      else if (cfg_size > 4'(DIM_MAX)) n_in = 4'(DIM_MAX);
      thr_in = (cfg_thr == 4'd0) ? 4'd1 : cfg_thr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         inner_ff <= '0;
         nm1_ff   <= '0;
         calls_ff <= '0;
         drain_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (go) begin
                  row_ff   <= '0;
                  col_ff   <= '0;
                  inner_ff <= '0;
                  nm1_ff   <= IDX_BITS'(n_in - 4'd1);
                  calls_ff <= calc_calls(n_in, thr_in);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (inner_ff == nm1_ff) begin
                  inner_ff <= '0;
                  if (col_ff == nm1_ff) begin
                     col_ff <= '0;
                     if (row_ff == nm1_ff) begin
                        drain_ff <= 2'd2;
                        state_ff <= ST_DRAIN;
                     end else begin
                        row_ff <= row_ff + 1'b1;
                     end
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end else begin
                  inner_ff <= inner_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               // wait for the last sum to leave the datapath
               if (drain_ff == 2'd0) state_ff <= ST_IDLE;
               else drain_ff <= drain_ff - 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd.issue     = (state_ff == ST_RUN);
      cmd.first     = (inner_ff == '0);
      cmd.last_z    = (inner_ff == nm1_ff);
      cmd.last_elem = (inner_ff == nm1_ff) && (col_ff == nm1_ff) && (row_ff == nm1_ff);
      cmd.row       = row_ff;
      cmd.col       = col_ff;
      cmd.inner     = inner_ff;
      cmd.calls     = calls_ff;
   end

endmodule

// ----- hdl/smm_dp.sv -----
// operand stores, multiply-accumulate pipeline and result registers
module smm_dp import smm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_a,
   input  logic                 load_b,
   input  logic [IDX_BITS-1:0]  ld_row,
   input  logic [IDX_BITS-1:0]  ld_col,
   input  logic [WORD_BITS-1:0] ld_value,
   input  cmd_type              cmd,
   output logic                 rsp_valid,
   output logic [IDX_BITS-1:0]  rsp_out_row,
   output logic [IDX_BITS-1:0]  rsp_out_col,
   output logic [WORD_BITS-1:0] rsp_product,
   output logic [CALL_BITS-1:0] rsp_call_count,
   output logic                 rsp_last
);

   logic [DEPTH-1:0]     valid_a_ff;
   logic [DEPTH-1:0]     valid_b_ff;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [ADDR_BITS-1:0] addr_a;
   logic [ADDR_BITS-1:0] addr_b;
   logic [WORD_BITS-1:0] data_a;
   logic [WORD_BITS-1:0] data_b;
   logic                 va_ff;
   logic                 vb_ff;
   cmd_type              s1_ff;
   cmd_type              s2_ff;
   logic [WORD_BITS-1:0] mul_in;
   logic [WORD_BITS-1:0] prod_ff;
   logic [WORD_BITS-1:0] acc_in;
   logic [WORD_BITS-1:0] acc_ff;
   logic                 rsp_valid_ff;
   logic [IDX_BITS-1:0]  rsp_row_ff;
   logic [IDX_BITS-1:0]  rsp_col_ff;
   logic [WORD_BITS-1:0] rsp_product_ff;
   logic [CALL_BITS-1:0] rsp_calls_ff;
   logic                 rsp_last_ff;

   assign wr_addr = {ld_row, ld_col};
   assign addr_a  = {cmd.row, cmd.inner};
   assign addr_b  = {cmd.inner, cmd.col};

   smm_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (load_a),
      .wr_addr (wr_addr),
      .wr_data (ld_value),
      .rd_addr (addr_a),
      .rd_data (data_a)
   );

   smm_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (load_b),
      .wr_addr (wr_addr),
      .wr_data (ld_value),
      .rd_addr (addr_b),
      .rd_data (data_b)
   );

   // entries never loaded since reset read as zero
   assign mul_in = (va_ff ? data_a : '0) * (vb_ff ? data_b : '0);
   assign acc_in = (s2_ff.first ? '0 : acc_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= '0;
         valid_b_ff   <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_a) valid_a_ff[wr_addr] <= 1'b1;
         if (load_b) valid_b_ff[wr_addr] <= 1'b1;
         s1_ff        <= cmd;
         s2_ff        <= s1_ff;
         rsp_valid_ff <= s2_ff.issue && s2_ff.last_z;
      end
   end

   always_ff @(posedge clock) begin
      va_ff   <= valid_a_ff[addr_a];
      vb_ff   <= valid_b_ff[addr_b];
      prod_ff <= mul_in;
      if (s2_ff.issue) acc_ff <= acc_in;
      rsp_row_ff     <= s2_ff.row;
      rsp_col_ff     <= s2_ff.col;
      rsp_product_ff <= acc_in;
      rsp_calls_ff   <= s2_ff.calls;
      rsp_last_ff    <= s2_ff.last_elem;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_product    = rsp_product_ff;
   assign rsp_call_count = rsp_calls_ff;
   assign rsp_last       = rsp_valid_ff && rsp_last_ff;

endmodule

// ----- hdl/strassen_matrix_multiply.sv -----
// top level of the strassen matrix multiplier
//
//  channel   | handshake                     | payload
//  request   | start in, busy out            | req_func, req_row, req_col, req_value
//  result    | rsp_valid out, one cycle      | rsp_out_row, rsp_out_col, rsp_product,
//            |                               | rsp_call_count, rsp_last
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// a load does not raise busy, so the next request may follow at once
// a multiply of active size n keeps busy high through ST_RUN and ST_DRAIN, one
// multiply-accumulate per cycle over the inner index
// each result leaves through the s1_ff and s2_ff stages and the result registers after its last inner step
// reset clears both operand stores at once through per-entry valid bits
module strassen_matrix_multiply import smm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_func,
   input  logic [IDX_BITS-1:0]  req_row,
   input  logic [IDX_BITS-1:0]  req_col,
   input  logic [WORD_BITS-1:0] req_value,
   output logic                 rsp_valid,
   output logic [IDX_BITS-1:0]  rsp_out_row,
   output logic [IDX_BITS-1:0]  rsp_out_col,
   output logic [WORD_BITS-1:0] rsp_product,
   output logic [CALL_BITS-1:0] rsp_call_count,
   output logic                 rsp_last,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic [CFG_BITS-1:0] size_ff;
   logic [CFG_BITS-1:0] thr_ff;
   logic                take;
   logic                go;
   logic                load_a;
   logic                load_b;
   cmd_type             cmd;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         thr_ff  <= THR_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == CFG_MATRIX_SIZE) size_ff <= pwdata[CFG_BITS-1:0];
         else thr_ff <= pwdata[CFG_BITS-1:0];
      end
   end

   assign prdata = (paddr[2] == CFG_MATRIX_SIZE) ? 32'(size_ff) : 32'(thr_ff);

   assign take   = start && !busy;
   assign go     = take && (req_func == FUNC_MULTIPLY);
   assign load_a = take && (req_func == FUNC_LOAD_A);
   assign load_b = take && (req_func == FUNC_LOAD_B);

   smm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .cfg_size (size_ff),
      .cfg_thr  (thr_ff),
      .busy     (busy),
      .cmd      (cmd)
   );

   smm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .load_a         (load_a),
      .load_b         (load_b),
      .ld_row         (req_row),
      .ld_col         (req_col),
      .ld_value       (req_value),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_product    (rsp_product),
      .rsp_call_count (rsp_call_count),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- hdl/smm_checker.sv -----
// port-level checks of the strassen matrix multiplier and their binding
module smm_assert import smm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [1:0]           req_func,
   input logic                 rsp_valid,
   input logic                 rsp_last
);

   // results only come out while a multiply is in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a multiply");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_MULTIPLY) |=> busy)
      else $error("multiply transfer did not raise busy");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without a result");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid) else $error("result right after last");

endmodule

bind strassen_matrix_multiply smm_assert u_smm_assert (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_func  (req_func),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);

// ----- tb/smm_checker.sv -----
// checker for the strassen matrix multiplier: tracks loads and settings, predicts and compares
`timescale 1ns / 100ps
module smm_checker import smm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [1:0]           req_func,
   input  logic [IDX_BITS-1:0]  req_row,
   input  logic [IDX_BITS-1:0]  req_col,
   input  logic [WORD_BITS-1:0] req_value,
   input  logic                 rsp_valid,
   input  logic [IDX_BITS-1:0]  rsp_out_row,
   input  logic [IDX_BITS-1:0]  rsp_out_col,
   input  logic [WORD_BITS-1:0] rsp_product,
   input  logic [CALL_BITS-1:0] rsp_call_count,
   input  logic                 rsp_last,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   input  logic                 pready,
   output int                   fail_count,
   output int                   pending
);

   typedef struct {
      logic [IDX_BITS-1:0]  out_row;
      logic [IDX_BITS-1:0]  out_col;
      logic [WORD_BITS-1:0] product;
      logic [CALL_BITS-1:0] call_count;
      logic                 last;
   } product_elem_type;

   logic [WORD_BITS-1:0] store_a [DEPTH];
   logic [WORD_BITS-1:0] store_b [DEPTH];
   logic [CFG_BITS-1:0]  size_reg;
   logic [CFG_BITS-1:0]  thr_reg;
   product_elem_type     product_q [$];

   // invocations of the seven-product recursion for padded side k
   function automatic int strassen_calls(int k, int thr);
      if (k <= thr || k < 2) return 1;
      return 1 + 7 * strassen_calls(k / 2, thr);
   endfunction

   // strassen with wraparound equals the plain product mod 2^32; padding adds zeros only
   task automatic predict_product();
      int n;
      int k;
      int thr;
      int calls;
      logic [WORD_BITS-1:0] acc;
      product_elem_type e;
      n = (size_reg < 1) ? 1 : (size_reg > DIM_MAX) ? DIM_MAX : int'(size_reg);
      k = 1;
      while (k < n) k = k * 2;
      thr = (thr_reg < 1) ? 1 : int'(thr_reg);
      calls = strassen_calls(k, thr);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int z = 0; z < n; z++)
               acc = acc + store_a[i*DIM_MAX+z] * store_b[z*DIM_MAX+j];
            e.out_row = IDX_BITS'(i);
            e.out_col = IDX_BITS'(j);
            e.product = acc;
            e.call_count = CALL_BITS'(calls);
            e.last = (i == n - 1) && (j == n - 1);
            product_q.push_back(e);
         end
      end
   endtask

   always @(posedge clock) begin
      product_elem_type exp_e;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            store_a[i] = '0;
            store_b[i] = '0;
         end
         size_reg = SIZE_RESET;
         thr_reg = THR_RESET;
         product_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CFG_MATRIX_SIZE) size_reg = pwdata[CFG_BITS-1:0];
            else thr_reg = pwdata[CFG_BITS-1:0];
         end
         if (rsp_valid) begin
            if (product_q.size() == 0) begin
               $error("unexpected product element row %0d col %0d", rsp_out_row, rsp_out_col);
               fail_count++;
            end else begin
               exp_e = product_q.pop_front();
               if (rsp_out_row !== exp_e.out_row) begin
                  $error("out_row: expected %0d, got %0d", exp_e.out_row, rsp_out_row);
                  fail_count++;
               end
               if (rsp_out_col !== exp_e.out_col) begin
                  $error("out_col: expected %0d, got %0d", exp_e.out_col, rsp_out_col);
                  fail_count++;
               end
               if (rsp_product !== exp_e.product) begin
                  $error("product: expected %h, got %h", exp_e.product, rsp_product);
                  fail_count++;
               end
               if (rsp_call_count !== exp_e.call_count) begin
                  $error("call_count: expected %0d, got %0d", exp_e.call_count,
                         rsp_call_count);
                  fail_count++;
               end
               if (rsp_last !== exp_e.last) begin
                  $error("last: expected %0d, got %0d", exp_e.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            case (req_func)
               FUNC_LOAD_A: store_a[{req_row, req_col}] = req_value;
               FUNC_LOAD_B: store_b[{req_row, req_col}] = req_value;
               FUNC_MULTIPLY: predict_product();
               default: ;
            endcase
         end
      end
      pending = product_q.size();
   end

endmodule

// ----- tb/tb_strassen_matrix_multiply.sv -----
// testbench top of the strassen matrix multiplier: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module tb_strassen_matrix_multiply;
   import smm_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NUM_PHASES = 12;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_func = FUNC_LOAD_A;
   logic [IDX_BITS-1:0]  req_row = '0;
   logic [IDX_BITS-1:0]  req_col = '0;
   logic [WORD_BITS-1:0] req_value = '0;
   logic                 rsp_valid;
   logic [IDX_BITS-1:0]  rsp_out_row;
   logic [IDX_BITS-1:0]  rsp_out_col;
   logic [WORD_BITS-1:0] rsp_product;
   logic [CALL_BITS-1:0] rsp_call_count;
   logic                 rsp_last;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [2:0]           paddr = '0;
   logic [31:0]          pwdata = '0;
   logic [31:0]          prdata;
   logic                 pready;
   int                   fail_count;
   int                   pending;
   int                   stall_cycles = 0;
   bit                   idling_on = 1'b1;

   always #4 clock = ~clock;

   strassen_matrix_multiply i_dut (
      .clock, .reset, .start, .busy, .req_func, .req_row, .req_col, .req_value,
      .rsp_valid, .rsp_out_row, .rsp_out_col, .rsp_product, .rsp_call_count, .rsp_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   smm_checker i_checker (
      .clock, .reset, .start, .busy, .req_func, .req_row, .req_col, .req_value,
      .rsp_valid, .rsp_out_row, .rsp_out_col, .rsp_product, .rsp_call_count, .rsp_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
   );

   // watchdog over cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("strassen_matrix_multiply test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_request(logic [1:0] func, logic [2:0] row, logic [2:0] col,
                               logic [31:0] value);
      start <= 1'b1;
      req_func <= func;
      req_row <= row;
      req_col <= col;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // lets the block drain before a register write
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [3:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {$urandom_range(0, 1) ? 28'hfffffff : 28'h0, value} & 32'h0000000f;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [3:0] size_set [NUM_PHASES];
      logic [3:0] thr_set [NUM_PHASES];
      int lim;
      int pick;
      logic [2:0] r;
      logic [2:0] c;

      size_set = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd0, 4'd15,
                   4'd5, 4'd8, 4'd3, 4'd6, 4'd7, 4'd8};
      thr_set  = '{4'd1, 4'd1, 4'd2, 4'd8, 4'd0, 4'd15,
                   4'd3, 4'd4, 4'd1, 4'd2, 4'd15, 4'd1};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: value extremes, corner elements, unused code, out of size loads
      send_request(FUNC_LOAD_A, 3'd0, 3'd0, 32'h7fffffff);
      send_request(FUNC_LOAD_A, 3'd0, 3'd1, 32'h80000000);
      send_request(FUNC_LOAD_A, 3'd7, 3'd7, 32'hffffffff);
      send_request(FUNC_LOAD_A, 3'd1, 3'd0, 32'h00000001);
      send_request(FUNC_LOAD_B, 3'd0, 3'd0, 32'h80000000);
      send_request(FUNC_LOAD_B, 3'd1, 3'd0, 32'h7fffffff);
      send_request(FUNC_LOAD_B, 3'd7, 3'd7, 32'hffffffff);
      send_request(FUNC_LOAD_B, 3'd0, 3'd7, 32'h55555555);
      send_request(FUNC_UNUSED, 3'd7, 3'd7, 32'hdeadbeef);
      send_request(FUNC_MULTIPLY, 3'd0, 3'd0, 32'h0);
      wait_quiet();
      write_csr(CFG_MATRIX_SIZE, 4'd3);
      send_request(FUNC_LOAD_A, 3'd5, 3'd6, 32'haaaaaaaa);
      send_request(FUNC_LOAD_B, 3'd6, 3'd5, 32'h12345678);
      send_request(FUNC_LOAD_A, 3'd2, 3'd2, 32'hfffffffe);
      send_request(FUNC_MULTIPLY, 3'd7, 3'd7, 32'hffffffff);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_quiet();
         write_csr(CFG_MATRIX_SIZE, size_set[p]);
         write_csr(CFG_DIRECT_THRESHOLD, thr_set[p]);
         idling_on = (p < NUM_PHASES - 3);
         lim = (size_set[p] == 0) ? 1 : (size_set[p] > 8) ? 8 : int'(size_set[p]);
         for (int it = 0; it < 13; it++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               r = 3'($urandom);
               c = 3'($urandom);
            end else begin
               r = 3'($urandom_range(0, lim - 1));
               c = 3'($urandom_range(0, lim - 1));
            end
            if (it == 12 || pick < 5)
               send_request(FUNC_MULTIPLY, 3'($urandom), 3'($urandom), $urandom);
            else if (pick < 10)
               send_request(FUNC_UNUSED, r, c, $urandom);
            else
               send_request(pick[0] ? FUNC_LOAD_B : FUNC_LOAD_A, r, c, $urandom);
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("strassen_matrix_multiply test passed");
      end else begin
         $display("strassen_matrix_multiply test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/smm_pkg.sv
hdl/smm_ram.sv
hdl/smm_ctrl.sv
hdl/smm_dp.sv
hdl/strassen_matrix_multiply.sv
hdl/smm_checker.sv
tb/smm_checker.sv
tb/tb_strassen_matrix_multiply.sv
